// ===== sv/top_k_rate_sample_tracker_core_assert.svh =====
// Assertion macros shared by the rate tracker RTL.
`ifndef TOP_K_RATE_SAMPLE_TRACKER_CORE_ASSERT_SVH
`define TOP_K_RATE_SAMPLE_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TKRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TKRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/tkrt_pkg.sv =====
// Types and constants of the rate tracker.
package tkrt_pkg;

  localparam int RATE_W = 32;
  localparam int TAG_W = 8;
  localparam int CFG_W = 4;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_INSERT,
    ST_MOVE,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SEARCH,
    OP_INS_START,
    OP_INSERT,
    OP_MOVE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic k_end;
    logic match;
    logic move_done;
  } sts_t;

endpackage

// ===== sv/tkrt_if.sv =====
// Channel interfaces of the rate tracker: input beats, result beats and configuration.
interface tkrt_in_if;
  logic                        valid;
  logic                        ready;
  logic [tkrt_pkg::RATE_W-1:0] rate_value;
  logic [tkrt_pkg::TAG_W-1:0]  rate_tag;

  modport source (output valid, output rate_value, output rate_tag, input ready);
  modport sink (input valid, input rate_value, input rate_tag, output ready);
endinterface

interface tkrt_out_if;
  logic                        valid;
  logic                        ready;
  logic [tkrt_pkg::RATE_W-1:0] max_rate;
  logic [tkrt_pkg::TAG_W-1:0]  max_tag;
  logic                        tag_hit;

  modport source (output valid, output max_rate, output max_tag, output tag_hit, input ready);
  modport sink (input valid, input max_rate, input max_tag, input tag_hit, output ready);
endinterface

interface tkrt_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tkrt_pkg::CFG_W-1:0] active_entries;

  modport source (output valid, output active_entries, input ready);
  modport sink (input valid, input active_entries, output ready);
endinterface

// ===== sv/tkrt_ctrl.sv =====
// Controller state machine that sequences the search, insert and move walks.
module tkrt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output tkrt_pkg::cmd_t cmd,
  input  tkrt_pkg::sts_t sts
);

  tkrt_pkg::state_t state_r;
  tkrt_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tkrt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.op       = tkrt_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    unique case (state_r)
      tkrt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = tkrt_pkg::OP_LOAD;
          state_nxt = tkrt_pkg::ST_SEARCH;
        end
      end
      tkrt_pkg::ST_SEARCH: begin
        if (sts.k_end) begin
          cmd.op    = tkrt_pkg::OP_INS_START;
          state_nxt = tkrt_pkg::ST_INSERT;
        end else begin
          cmd.op = tkrt_pkg::OP_SEARCH;
          if (sts.match) begin
            state_nxt = tkrt_pkg::ST_MOVE;
          end
        end
      end
      tkrt_pkg::ST_INSERT: begin
        if (sts.k_end) begin
          state_nxt = tkrt_pkg::ST_DONE;
        end else begin
          cmd.op = tkrt_pkg::OP_INSERT;
        end
      end
      tkrt_pkg::ST_MOVE: begin
        cmd.op = tkrt_pkg::OP_MOVE;
        if (sts.move_done) begin
          state_nxt = tkrt_pkg::ST_DONE;
        end
      end
      tkrt_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = tkrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tkrt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & ~out_ready);
  assign out_valid     = out_valid_r;

endmodule

// ===== sv/tkrt_dpath.sv =====
// Datapath of the rate tracker: slot store, walk pointer, carried pair and result register.
module tkrt_dpath #(
  parameter int MAX_SLOTS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tkrt_pkg::CFG_W-1:0]  cfg_data,
  input  logic [tkrt_pkg::RATE_W-1:0] in_rate,
  input  logic [tkrt_pkg::TAG_W-1:0]  in_tag,
  input  tkrt_pkg::cmd_t              cmd,
  output tkrt_pkg::sts_t              sts,
  output logic [tkrt_pkg::RATE_W-1:0] out_rate,
  output logic [tkrt_pkg::TAG_W-1:0]  out_tag,
  output logic                        out_hit
);

  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CMP_W = (CNT_W > tkrt_pkg::CFG_W) ? CNT_W : tkrt_pkg::CFG_W;

  logic [tkrt_pkg::RATE_W-1:0] slot_rate_r [MAX_SLOTS];
  logic [tkrt_pkg::TAG_W-1:0]  slot_tag_r  [MAX_SLOTS];
  logic [tkrt_pkg::CFG_W-1:0]  active_r;

  logic [CNT_W-1:0]            k_r;
  logic [CNT_W-1:0]            k_nxt;
  logic [tkrt_pkg::RATE_W-1:0] carry_rate_r;
  logic [tkrt_pkg::RATE_W-1:0] carry_rate_nxt;
  logic [tkrt_pkg::TAG_W-1:0]  carry_tag_r;
  logic [tkrt_pkg::TAG_W-1:0]  carry_tag_nxt;
  logic                        hit_r;
  logic                        hit_nxt;
  logic                        down_r;
  logic                        down_nxt;
  logic [tkrt_pkg::RATE_W-1:0] out_rate_r;
  logic [tkrt_pkg::TAG_W-1:0]  out_tag_r;
  logic                        out_hit_r;

  logic [CMP_W-1:0]            act_ext;
  logic [CNT_W-1:0]            n_eff;
  logic [CNT_W:0]              k_inc;
  logic [CNT_W-1:0]            k_dec;
  logic [IDX_W-1:0]            rd_idx;
  logic [IDX_W-1:0]            wr_idx;
  logic [tkrt_pkg::RATE_W-1:0] rd_rate;
  logic [tkrt_pkg::TAG_W-1:0]  rd_tag;
  logic                        move_ok;
  logic                        wr_en;
  logic [tkrt_pkg::RATE_W-1:0] wr_rate;
  logic [tkrt_pkg::TAG_W-1:0]  wr_tag;

  assign act_ext = CMP_W'(active_r);
  assign n_eff   = (act_ext > CMP_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(act_ext);
  assign k_inc   = (CNT_W + 1)'(k_r) + (CNT_W + 1)'(1);
  assign k_dec   = k_r - CNT_W'(1);
  assign wr_idx  = k_r[IDX_W-1:0];

  always_comb begin
    if (cmd.op == tkrt_pkg::OP_MOVE) begin
      rd_idx = down_r ? k_inc[IDX_W-1:0] : k_dec[IDX_W-1:0];
    end else begin
      rd_idx = k_r[IDX_W-1:0];
    end
  end

  assign rd_rate = slot_rate_r[rd_idx];
  assign rd_tag  = slot_tag_r[rd_idx];

  assign move_ok = down_r ? ((k_inc < (CNT_W + 1)'(n_eff)) && (carry_rate_r < rd_rate))
                          : ((k_r != '0) && (carry_rate_r > rd_rate));

  assign sts.k_end     = (k_r == n_eff);
  assign sts.match     = (rd_tag == carry_tag_r);
  assign sts.move_done = ~move_ok;

  always_comb begin
    k_nxt          = k_r;
    carry_rate_nxt = carry_rate_r;
    carry_tag_nxt  = carry_tag_r;
    hit_nxt        = hit_r;
    down_nxt       = down_r;
    wr_en          = 1'b0;
    wr_rate        = carry_rate_r;
    wr_tag         = carry_tag_r;
    unique case (cmd.op)
      tkrt_pkg::OP_NONE: begin
      end
      tkrt_pkg::OP_LOAD: begin
        k_nxt          = '0;
        carry_rate_nxt = in_rate;
        carry_tag_nxt  = in_tag;
        hit_nxt        = 1'b0;
        down_nxt       = 1'b0;
      end
      tkrt_pkg::OP_SEARCH: begin
        if (rd_tag == carry_tag_r) begin
          hit_nxt  = 1'b1;
          down_nxt = (rd_rate > carry_rate_r);
        end else begin
          k_nxt = k_inc[CNT_W-1:0];
        end
      end
      tkrt_pkg::OP_INS_START: begin
        k_nxt = '0;
      end
      tkrt_pkg::OP_INSERT: begin
        if (carry_rate_r > rd_rate) begin
          wr_en          = 1'b1;
          carry_rate_nxt = rd_rate;
          carry_tag_nxt  = rd_tag;
        end
        k_nxt = k_inc[CNT_W-1:0];
      end
      tkrt_pkg::OP_MOVE: begin
        wr_en = 1'b1;
        if (move_ok) begin
          wr_rate = rd_rate;
          wr_tag  = rd_tag;
          k_nxt   = down_r ? k_inc[CNT_W-1:0] : k_dec;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_rate_r[i] <= '0;
        slot_tag_r[i]  <= '0;
      end
    end else if (wr_en) begin
      slot_rate_r[wr_idx] <= wr_rate;
      slot_tag_r[wr_idx]  <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= tkrt_pkg::ACTIVE_RESET;
      k_r      <= '0;
      hit_r    <= 1'b0;
      down_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_r <= cfg_data;
      end
      k_r    <= k_nxt;
      hit_r  <= hit_nxt;
      down_r <= down_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_rate_r <= carry_rate_nxt;
    carry_tag_r  <= carry_tag_nxt;
    if (cmd.out_load) begin
      out_rate_r <= slot_rate_r[0];
      out_tag_r  <= slot_tag_r[0];
      out_hit_r  <= hit_r;
    end
  end

  assign out_rate = out_rate_r;
  assign out_tag  = out_tag_r;
  assign out_hit  = out_hit_r;

endmodule

// ===== sv/top_k_rate_sample_tracker_core.sv =====
// Top level of the rate tracker: a sorted list of (tag, rate) pairs, largest rate first.
//
// The in_ch channel takes one beat per rate sample (rate_value, rate_tag). The out_ch
// channel returns one beat per sample with the head slot after the update (max_rate,
// max_tag) and tag_hit, which is set when the tag was already in the list.
// The cfg_ch channel writes active_entries; it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// A sample walks the list one slot per cycle through a single read port of the slot
// store. With n active slots, the result beat of a sample whose tag is missing is
// presented after a search walk over all n slots and an insert walk over them; for a
// hit it waits for the search walk and the bubbling walk that follows it.
// The next sample is accepted once the result of the previous one has entered the output
// register, even while its result beat still waits there.
// If the receiver stalls with a result still pending, a finished sample waits in
// its last state until the output register frees up, and no new sample is taken.
// Reset clears all slots to rate 0 and tag 0, sets active_entries to 3 and
// empties the output register.
`include "top_k_rate_sample_tracker_core_assert.svh"

module top_k_rate_sample_tracker_core #(
  parameter int MAX_SLOTS = 8
) (
  input logic         clk,
  input logic         rst_n,
  tkrt_in_if.sink     in_ch,
  tkrt_out_if.source  out_ch,
  tkrt_cfg_if.sink    cfg_ch
);

  tkrt_pkg::cmd_t cmd;
  tkrt_pkg::sts_t sts;

  assign cfg_ch.ready = 1'b1;

  tkrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tkrt_dpath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_ch.valid),
    .cfg_data (cfg_ch.active_entries),
    .in_rate  (in_ch.rate_value),
    .in_tag   (in_ch.rate_tag),
    .cmd      (cmd),
    .sts      (sts),
    .out_rate (out_ch.max_rate),
    .out_tag  (out_ch.max_tag),
    .out_hit  (out_ch.tag_hit)
  );

  `TKRT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `TKRT_ASSERT_NOW(a_load_only_on_accept, clk, rst_n, cmd.op == tkrt_pkg::OP_LOAD, in_ch.valid && in_ch.ready)
  `TKRT_ASSERT_NOW(a_no_result_overwrite, clk, rst_n, cmd.out_load, !out_ch.valid || out_ch.ready)
  `TKRT_ASSERT_NEXT(a_result_shown, clk, rst_n, cmd.out_load, out_ch.valid)

endmodule
